// ===== rtl/core/ste_pkg.sv =====
// Shared constants, types and codes of the session table engine.
package ste_pkg;

    // Table geometry
    localparam int NUM_SLOTS = 16;
    localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    // Field widths
    localparam int MODE_W   = 3;
    localparam int PORT_W   = 16;
    localparam int SLOTIN_W = 4;
    localparam int STATE_W  = 8;
    localparam int HANDLE_W = 32;
    localparam int STATUS_W = 2;
    localparam int DATA_W   = STATE_W + HANDLE_W;

    // Request modes; codes five to seven are unused
    typedef enum logic [MODE_W-1:0] {
        MODE_FIND = 3'd0,
        MODE_ADD  = 3'd1,
        MODE_READ = 3'd2,
        MODE_SAVE = 3'd3,
        MODE_FREE = 3'd4
    } t_mode;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

    typedef logic [SLOT_W-1:0] t_idx;

endpackage

// ===== rtl/core/ste_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module ste_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write one entry; read one entry, with the data ready in the cycle after its address
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/session_table_engine.sv =====
// Top level of the session table engine: request sequencer and slot stores.
//
// One request is taken when start is high and busy is low; exactly one result beat follows,
// shown for one cycle with o_valid, and the receiver cannot stall it. Save, free and
// unused modes answer in the next cycle and never raise busy; so does a read out of range.
// A read in range holds busy while the slot memories are read. Find walks the port memory
// one slot per cycle, lowest slot first, with registered read data; it ends at the first
// valid match, or reports not found after the last slot. Add walks the valid marks one slot
// per cycle, ending at the first free slot or reporting full. The stores read as zero from reset until
// written, tracked by per-slot written marks, so no clearing pass is run after reset.
module session_table_engine
    import ste_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [MODE_W-1:0]   i_mode,
    input  logic [PORT_W-1:0]   i_port,
    input  logic [SLOTIN_W-1:0] i_slot,
    input  logic [STATE_W-1:0]  i_state_in,
    input  logic [HANDLE_W-1:0] i_handle_in,
    output logic                o_valid,
    output logic [STATUS_W-1:0] o_status,
    output logic [SLOTIN_W-1:0] o_slot_out,
    output logic [PORT_W-1:0]   o_port_out,
    output logic [STATE_W-1:0]  o_state_out,
    output logic [HANDLE_W-1:0] o_handle_out
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_FIND,
        S_ADD,
        S_READ
    } t_fsm;

    localparam t_idx LAST_IDX = SLOT_W'(NUM_SLOTS - 1);

    t_fsm                r_fsm;
    t_idx                r_idx;
    logic                r_chk;
    t_idx                r_chk_idx;
    logic [NUM_SLOTS-1:0] r_valid_bits;
    logic [NUM_SLOTS-1:0] r_port_wr;
    logic [NUM_SLOTS-1:0] r_data_wr;
    logic [PORT_W-1:0]   r_port;
    logic [STATE_W-1:0]  r_state_val;
    logic [HANDLE_W-1:0] r_handle;
    logic                r_valid;
    logic [STATUS_W-1:0] r_status;
    logic [SLOTIN_W-1:0] r_slot_out;
    logic [PORT_W-1:0]   r_port_out;
    logic [STATE_W-1:0]  r_state_out;
    logic [HANDLE_W-1:0] r_handle_out;

    logic                accept;
    logic                in_range;
    t_idx                in_idx;
    t_idx                raddr;
    logic                port_we;
    logic                data_we;
    t_idx                data_waddr;
    logic [DATA_W-1:0]   data_wdata;
    logic [PORT_W-1:0]   port_rdata;
    logic [DATA_W-1:0]   data_rdata;
    logic                find_hit;
    logic                add_free;

    assign accept   = start && (r_fsm == S_IDLE);
    assign in_range = 32'(i_slot) < NUM_SLOTS;
    assign in_idx   = SLOT_W'(i_slot);

    // Steer the shared read address: input slot while idle, scan index otherwise
    assign raddr = (r_fsm == S_IDLE) ? in_idx : r_idx;

    // Add writes all fields of the claimed slot; save writes state and handle
    assign add_free   = (r_fsm == S_ADD) && !r_valid_bits[r_idx];
    assign port_we    = add_free;
    assign data_we    = add_free || (accept && (i_mode == MODE_SAVE) && in_range);
    assign data_waddr = add_free ? r_idx : in_idx;
    assign data_wdata = add_free ? {r_state_val, r_handle} : {i_state_in, i_handle_in};

    // Compare the port read for the previous scan index against the searched port, if that slot is valid
    assign find_hit = r_chk && r_valid_bits[r_chk_idx] && (port_rdata == r_port);

    ste_ram #(
        .WIDTH (PORT_W),
        .DEPTH (NUM_SLOTS)
    ) u_port_ram (
        .i_clk   (i_clk),
        .i_we    (port_we),
        .i_waddr (r_idx),
        .i_wdata (r_port),
        .i_raddr (raddr),
        .o_rdata (port_rdata)
    );

    ste_ram #(
        .WIDTH (DATA_W),
        .DEPTH (NUM_SLOTS)
    ) u_data_ram (
        .i_clk   (i_clk),
        .i_we    (data_we),
        .i_waddr (data_waddr),
        .i_wdata (data_wdata),
        .i_raddr (raddr),
        .o_rdata (data_rdata)
    );

    // Sequence requests, track slot marks and register the result beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm        <= S_IDLE;
            r_idx        <= '0;
            r_chk        <= 1'b0;
            r_valid_bits <= '0;
            r_port_wr    <= '0;
            r_data_wr    <= '0;
            r_valid      <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            case (r_fsm)
                S_IDLE: begin
                    if (accept) begin
                        r_port       <= i_port;
                        r_state_val  <= i_state_in;
                        r_handle     <= i_handle_in;
                        r_status     <= ST_DONE;
                        r_slot_out   <= i_slot;
                        r_port_out   <= '0;
                        r_state_out  <= '0;
                        r_handle_out <= '0;
                        case (i_mode)
                            MODE_FIND: begin
                                r_idx <= '0;
                                r_chk <= 1'b0;
                                r_fsm <= S_FIND;
                            end
                            MODE_ADD: begin
                                r_idx <= '0;
                                r_fsm <= S_ADD;
                            end
                            MODE_READ: begin
                                r_idx <= in_idx;
                                if (in_range) begin
                                    r_fsm <= S_READ;
                                end else begin
                                    r_valid <= 1'b1;
                                end
                            end
                            MODE_SAVE: begin
                                if (in_range) begin
                                    r_data_wr[in_idx] <= 1'b1;
                                end
                                r_valid <= 1'b1;
                            end
                            MODE_FREE: begin
                                if (in_range) begin
                                    r_valid_bits[in_idx] <= 1'b0;
                                end
                                r_valid <= 1'b1;
                            end
                            default: begin
                                r_valid <= 1'b1;
                            end
                        endcase
                    end
                end
                S_FIND: begin
                    // Issue the next read while checking the previous one
                    r_chk     <= 1'b1;
                    r_chk_idx <= r_idx;
                    if (r_idx != LAST_IDX) begin
                        r_idx <= r_idx + 1'b1;
                    end
                    if (find_hit) begin
                        r_status   <= ST_DONE;
                        r_slot_out <= SLOTIN_W'(r_chk_idx);
                        r_valid    <= 1'b1;
                        r_fsm      <= S_IDLE;
                    end else if (r_chk && (r_chk_idx == LAST_IDX)) begin
                        r_status   <= ST_NOT_FOUND;
                        r_slot_out <= '0;
                        r_valid    <= 1'b1;
                        r_fsm      <= S_IDLE;
                    end
                end
                S_ADD: begin
                    if (add_free) begin
                        r_valid_bits[r_idx] <= 1'b1;
                        r_port_wr[r_idx]    <= 1'b1;
                        r_data_wr[r_idx]    <= 1'b1;
                        r_status            <= ST_DONE;
                        r_slot_out          <= SLOTIN_W'(r_idx);
                        r_valid             <= 1'b1;
                        r_fsm               <= S_IDLE;
                    end else if (r_idx == LAST_IDX) begin
                        r_status   <= ST_FULL;
                        r_slot_out <= '0;
                        r_valid    <= 1'b1;
                        r_fsm      <= S_IDLE;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_READ: begin
                    // Unwritten entries read as zero
                    r_port_out   <= r_port_wr[r_idx] ? port_rdata : '0;
                    r_state_out  <= r_data_wr[r_idx] ? data_rdata[DATA_W-1:HANDLE_W] : '0;
                    r_handle_out <= r_data_wr[r_idx] ? data_rdata[HANDLE_W-1:0] : '0;
                    r_valid      <= 1'b1;
                    r_fsm        <= S_IDLE;
                end
                default: begin
                    r_fsm <= S_IDLE;
                end
            endcase
        end
    end

    assign busy         = (r_fsm != S_IDLE);
    assign o_valid      = r_valid;
    assign o_status     = r_status;
    assign o_slot_out   = r_slot_out;
    assign o_port_out   = r_port_out;
    assign o_state_out  = r_state_out;
    assign o_handle_out = r_handle_out;

    // Every accepted request either answers next cycle or keeps the engine busy
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_valid || busy))
        else $error("accepted request neither answered nor in progress");

    // A result beat is shown only once the engine is idle again
    a_valid_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> !busy)
        else $error("result beat while busy");

    // Claiming a free slot marks it valid on the next cycle
    a_add_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        add_free |=> r_valid_bits[$past(r_idx)])
        else $error("claimed slot not marked valid");

    // A find hit always reports success
    a_find_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fsm == S_FIND) && find_hit |=> (r_valid && (r_status == ST_DONE)))
        else $error("find hit not reported as done");

endmodule

// ===== bench/session_table_engine_tb.sv =====
// Self-checking testbench for the session table engine: queued requests, live predictor.
`timescale 1ns / 1ps

module session_table_engine_tb;
    import ste_pkg::*;

    // Unused request codes, sent to check that they leave the table alone
    localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd5;
    localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;

    localparam int RANDOM_REQUESTS = 1700;
    localparam int QUIET_TAIL      = 150;
    localparam int DRAIN_CYCLES    = NUM_SLOTS + 8;

    typedef struct packed {
        logic [MODE_W-1:0]   mode;
        logic [PORT_W-1:0]   port;
        logic [SLOTIN_W-1:0] slot;
        logic [STATE_W-1:0]  state;
        logic [HANDLE_W-1:0] handle;
    } session_request_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOTIN_W-1:0] slot;
        logic [PORT_W-1:0]   port;
        logic [STATE_W-1:0]  state;
        logic [HANDLE_W-1:0] handle;
    } session_result_t;

    logic                i_clk        = 1'b0;
    logic                i_rst_n      = 1'b0;
    logic                start        = 1'b0;
    logic [MODE_W-1:0]   i_mode       = '0;
    logic [PORT_W-1:0]   i_port       = '0;
    logic [SLOTIN_W-1:0] i_slot       = '0;
    logic [STATE_W-1:0]  i_state_in   = '0;
    logic [HANDLE_W-1:0] i_handle_in  = '0;
    logic                busy;
    logic                o_valid;
    logic [STATUS_W-1:0] o_status;
    logic [SLOTIN_W-1:0] o_slot_out;
    logic [PORT_W-1:0]   o_port_out;
    logic [STATE_W-1:0]  o_state_out;
    logic [HANDLE_W-1:0] o_handle_out;

    // Shadow copy of the session table
    logic                slot_live   [NUM_SLOTS];
    logic [PORT_W-1:0]   slot_port   [NUM_SLOTS];
    logic [STATE_W-1:0]  slot_state  [NUM_SLOTS];
    logic [HANDLE_W-1:0] slot_handle [NUM_SLOTS];

    session_request_t pending_requests [$];
    session_result_t  expected_results [$];

    int requests_total = 0;
    int requests_taken = 0;
    int requests_sent  = 0;
    int idle_left      = 0;
    int idle_odds      = 0;
    int error_count    = 0;

    logic [PORT_W-1:0] port_pool [8] = '{16'h0000, 16'hFFFF, 16'h0001, 16'h8000,
                                         16'h1234, 16'h5A5A, 16'hA5A5, 16'h7FFF};

    session_table_engine DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_mode       (i_mode),
        .i_port       (i_port),
        .i_slot       (i_slot),
        .i_state_in   (i_state_in),
        .i_handle_in  (i_handle_in),
        .o_valid      (o_valid),
        .o_status     (o_status),
        .o_slot_out   (o_slot_out),
        .o_port_out   (o_port_out),
        .o_state_out  (o_state_out),
        .o_handle_out (o_handle_out)
    );

    // 100 MHz clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Apply one request to the shadow table and return the result it must produce
    function automatic session_result_t apply_request(session_request_t req);
        session_result_t res;
        logic            in_table;
        res        = '0;
        res.status = ST_DONE;
        res.slot   = req.slot;
        in_table   = (int'(req.slot) < NUM_SLOTS);
        case (req.mode)
            MODE_FIND: begin
                res.status = ST_NOT_FOUND;
                res.slot   = '0;
                for (int i = 0; i < NUM_SLOTS; i++) begin
                    if (slot_live[i] && slot_port[i] == req.port) begin
                        res.status = ST_DONE;
                        res.slot   = SLOTIN_W'(i);
                        break;
                    end
                end
            end
            MODE_ADD: begin
                res.status = ST_FULL;
                res.slot   = '0;
                for (int i = 0; i < NUM_SLOTS; i++) begin
                    if (!slot_live[i]) begin
                        slot_live[i]   = 1'b1;
                        slot_port[i]   = req.port;
                        slot_state[i]  = req.state;
                        slot_handle[i] = req.handle;
                        res.status     = ST_DONE;
                        res.slot       = SLOTIN_W'(i);
                        break;
                    end
                end
            end
            MODE_READ: begin
                // Contents come back whether or not the slot is live
                if (in_table) begin
                    res.port   = slot_port[req.slot];
                    res.state  = slot_state[req.slot];
                    res.handle = slot_handle[req.slot];
                end
            end
            MODE_SAVE: begin
                if (in_table) begin
                    slot_state[req.slot]  = req.state;
                    slot_handle[req.slot] = req.handle;
                end
            end
            MODE_FREE: begin
                if (in_table)
                    slot_live[req.slot] = 1'b0;
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    task automatic queue_request(logic [MODE_W-1:0] mode, logic [PORT_W-1:0] port,
                                 logic [SLOTIN_W-1:0] slot, logic [STATE_W-1:0] state,
                                 logic [HANDLE_W-1:0] handle);
        pending_requests.push_back('{mode, port, slot, state, handle});
        requests_total++;
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            error_count++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    // Mostly ports from a small pool so that finds hit and duplicates form
    function automatic logic [PORT_W-1:0] pick_port();
        if ($urandom_range(0, 3) != 0)
            return port_pool[$urandom_range(0, 7)];
        return PORT_W'($urandom);
    endfunction

    // Driver: present the next request, hold it while busy, idle in random bursts
    always @(posedge i_clk) begin : drive_requests
        session_request_t next_req;
        if (i_rst_n) begin
            if (start && busy) begin
                // hold the current beat
            end else if (idle_left != 0) begin
                idle_left--;
                start <= 1'b0;
            end else if (pending_requests.size() == 0) begin
                start <= 1'b0;
            end else if (pending_requests.size() > QUIET_TAIL && idle_odds != 0 &&
                         $urandom_range(0, 3 * idle_odds) == 0) begin
                idle_left = $urandom_range(1, 18) - 1;
                start <= 1'b0;
            end else begin
                next_req = pending_requests.pop_front();
                requests_sent++;
                if (requests_sent % 50 == 0)
                    idle_odds = $urandom_range(0, 3);
                start       <= 1'b1;
                i_mode      <= next_req.mode;
                i_port      <= next_req.port;
                i_slot      <= next_req.slot;
                i_state_in  <= next_req.state;
                i_handle_in <= next_req.handle;
            end
        end
    end

    // Monitor: predict on each accepted request, check each result beat
    always @(posedge i_clk) begin : watch_results
        session_result_t want;
        if (i_rst_n) begin
            if (start && !busy) begin
                expected_results.push_back(apply_request(
                    '{i_mode, i_port, i_slot, i_state_in, i_handle_in}));
                requests_taken++;
            end
            if (o_valid) begin
                if (expected_results.size() == 0) begin
                    error_count++;
                    $display("%0t: result beat with none expected, status %0h slot %0h",
                             $time, o_status, o_slot_out);
                end else begin
                    want = expected_results.pop_front();
                    check_field("status", 32'(want.status), 32'(o_status));
                    check_field("slot_out", 32'(want.slot), 32'(o_slot_out));
                    check_field("port_out", 32'(want.port), 32'(o_port_out));
                    check_field("state_out", 32'(want.state), 32'(o_state_out));
                    check_field("handle_out", want.handle, o_handle_out);
                end
            end
        end
    end

    // Stimulus and end of run
    initial begin : stimulus
        int pick;
        int phase;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            slot_live[i]   = 1'b0;
            slot_port[i]   = '0;
            slot_state[i]  = '0;
            slot_handle[i] = '0;
        end

        // Directed: empty table, extremes, duplicates, spare codes, full table
        queue_request(MODE_READ, 16'h0000, 4'hF, 8'h00, 32'h0);
        queue_request(MODE_FIND, 16'h0000, 4'h0, 8'h00, 32'h0);
        queue_request(MODE_ADD, 16'h0000, 4'hF, 8'hFF, 32'hFFFF_FFFF);
        queue_request(MODE_ADD, 16'hFFFF, 4'h0, 8'h00, 32'h0000_0000);
        queue_request(MODE_ADD, 16'hFFFF, 4'h7, 8'h5A, 32'hA5A5_5A5A);
        queue_request(MODE_FIND, 16'hFFFF, 4'hF, 8'h00, 32'h0);
        queue_request(MODE_FREE, 16'h0000, 4'h0, 8'h00, 32'h0);
        queue_request(MODE_FIND, 16'h0000, 4'h0, 8'h00, 32'h0);
        queue_request(MODE_SAVE, 16'h0000, 4'h5, 8'hC3, 32'hDEAD_BEEF);
        queue_request(MODE_READ, 16'h0000, 4'h5, 8'h00, 32'h0);
        queue_request(MODE_SPARE_LO, 16'hFFFF, 4'hA, 8'hFF, 32'hFFFF_FFFF);
        queue_request(MODE_SPARE_HI, 16'h0000, 4'hF, 8'hFF, 32'hFFFF_FFFF);
        for (int i = 0; i < NUM_SLOTS - 2; i++)
            queue_request(MODE_ADD, PORT_W'(16'h4000 + i), 4'(i), 8'(i), 32'h1000_0000 + i);
        queue_request(MODE_ADD, 16'hBEEF, 4'h3, 8'h11, 32'h2222_2222);

        // Random: alternate fill-heavy, drain-heavy and mixed stretches
        phase = 0;
        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            if (n % 40 == 0)
                phase = $urandom_range(0, 2);
            pick = $urandom_range(0, 99);
            if (phase == 0)
                pick = (pick < 45) ? 0 : (pick < 52) ? 1 : pick;
            else if (phase == 1)
                pick = (pick < 10) ? 0 : (pick < 45) ? 1 : pick;
            else
                pick = (pick < 25) ? 0 : (pick < 45) ? 1 : pick;
            if (pick == 0)
                queue_request(MODE_ADD, pick_port(), 4'($urandom), 8'($urandom), $urandom);
            else if (pick == 1)
                queue_request(MODE_FREE, pick_port(), 4'($urandom), 8'($urandom), $urandom);
            else if (pick < 70)
                queue_request(MODE_FIND, pick_port(), 4'($urandom), 8'($urandom), $urandom);
            else if (pick < 82)
                queue_request(MODE_READ, pick_port(), 4'($urandom), 8'($urandom), $urandom);
            else if (pick < 94)
                queue_request(MODE_SAVE, pick_port(), 4'($urandom), 8'($urandom), $urandom);
            else
                queue_request(3'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI)), pick_port(),
                              4'($urandom), 8'($urandom), $urandom);
        end

        // Hold reset low, then release it
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for every beat to be taken and answered, then let the block settle
        while (requests_taken < requests_total)
            @(negedge i_clk);
        while (expected_results.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (expected_results.size() != 0) begin
            error_count++;
            $display("%0t: %0d results never arrived", $time, expected_results.size());
        end

        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Watchdog
    initial begin : watchdog
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
